/* sv/sha1_pkg.sv */
// Package: shared types and constants for the SHA-1 digest block.
`timescale 1ns / 1ps
package sha1_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = 2;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PadByte = 8'h80;

  // Queued transaction from front to back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha1_item_t;

endpackage

/* sv/sha1_message_digest.sv */
// Top level: SHA-1 digest of a byte stream, five digest words per message.
// Usage:
//   Input channel: one transaction per byte (in_byte_present=1) or a closing
//   transaction with in_end_of_message=1 and optionally no byte. Items with
//   neither are accepted and ignored.
//   Output channel: on each end of message, five transactions carry the
//   digest words H0..H4, index 0 first, out_last_word on the fifth.
//   A byte that completes a 64-byte block is taken, then compressed in 80
//   rounds at one per cycle, then added into the hash words; other bytes
//   are only packed into the block. A message end adds one or two padding
//   blocks (pad or length load, 80 rounds, add), then five output words.
//   Compression is a single-round loop; no new byte is taken while its
//   rounds run. A four-entry queue in front lets input continue while rounds
//   run.
//   Reset (rst_n low, synchronous) restores the initial hash words and
//   clears length and queue. A stalled output holds its word; processing
//   of later items waits until all five words are taken.
`timescale 1ns / 1ps
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha1_pkg::*;

  sha1_item_t q_item;
  logic       q_valid, q_take;

  sha1_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_byte_present,
    .in_end_of_message, .q_valid, .q_item, .q_take
  );

  sha1_core u_core (
    .clk, .rst_n, .q_valid, .q_item, .q_take, .out_valid, .out_stall,
    .out_digest_word, .out_word_index, .out_last_word
  );
endmodule

/* sv/sha1_front.sv */
// Front end: accepts input transactions, drops idle ones, queues the rest.
`timescale 1ns / 1ps
module sha1_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_byte_present,
  input  logic                in_end_of_message,
  output logic                q_valid,
  output sha1_pkg::sha1_item_t q_item,
  input  logic                q_take
);
  import sha1_pkg::*;

  sha1_item_t        mem_r [QDepth];
  logic [QAw-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAw:0]      cnt_r, cnt_nxt;
  logic              push, pop;

  assign in_stall = (cnt_r == (QAw+1)'(QDepth));
  // idle items (no byte, no end) are accepted and dropped here
  assign push = in_valid && !in_stall && (in_byte_present || in_end_of_message);
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];
  assign pop = q_valid && q_take;

  always_comb begin
    wp_nxt  = push ? wp_r + QAw'(1) : wp_r;
    rp_nxt  = pop ? rp_r + QAw'(1) : rp_r;
    cnt_nxt = cnt_r + (QAw+1)'(push) - (QAw+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= '{data_byte: in_data_byte, byte_present: in_byte_present,
                       end_of_message: in_end_of_message};
    end
  end
endmodule

/* sv/sha1_core.sv */
// Back end: block packing, padding, 80-round compression and digest output.
`timescale 1ns / 1ps
module sha1_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  sha1_pkg::sha1_item_t q_item,
  output logic                 q_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_digest_word,
  output logic [2:0]           out_word_index,
  output logic                 out_last_word
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_LOAD = 3'd5;

  logic [2:0]  st_r;
  logic [31:0] w_r [16];          // sliding schedule window
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [63:0] len_r;
  logic [6:0]  rnd_r;
  logic        fin_r;             // last compression of the message
  logic        pad_r;             // full block also ended the message
  logic        lenblk_r;          // length-only block still to follow
  logic [2:0]  oidx_r;

  logic [5:0]  pos;
  logic [3:0]  wsel;
  logic [31:0] f, k, t, wx, wnew, wcur;

  // big-endian byte lane insert; bytes below the lane are cleared
  function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] sel, logic [7:0] b);
    case (sel)
      2'd0:    put_byte = {b, 24'd0};
      2'd1:    put_byte = {w[31:24], b, 16'd0};
      2'd2:    put_byte = {w[31:16], b, 8'd0};
      default: put_byte = {w[31:8], b};
    endcase
  endfunction

  assign pos  = len_r[8:3];
  assign wsel = pos[5:2];
  assign wcur = w_r[0];
  assign wx   = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign wnew = {wx[30:0], wx[31]};

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r; k = K3;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + wcur;
  end

  assign q_take    = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      len_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      pad_r <= 1'b0;
      lenblk_r <= 1'b0;
      oidx_r <= '0;
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0; e_r <= '0;
      h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          if (q_item.byte_present) begin
            w_r[wsel] <= put_byte(w_r[wsel], pos[1:0], q_item.data_byte);
            len_r <= len_r + 64'd8;
          end
          if (q_item.byte_present && pos == 6'd63) begin
            // full block: compress, padding follows if the message ends here
            pad_r <= q_item.end_of_message;
            fin_r <= 1'b0;
            lenblk_r <= 1'b0;
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
            rnd_r <= '0;
            st_r <= S_RND;
          end else if (q_item.end_of_message) begin
            st_r <= S_PAD;
          end
        end
        S_PAD: begin
          // pad at current position; len_r already includes the last byte
          for (int i = 0; i < 16; i++) begin
            if (4'(i) == wsel) begin
              w_r[i] <= put_byte(w_r[i], pos[1:0], PadByte);
            end else if (4'(i) > wsel) begin
              if (pos < 6'd56 && i == 14) w_r[i] <= len_r[63:32];
              else if (pos < 6'd56 && i == 15) w_r[i] <= len_r[31:0];
              else w_r[i] <= '0;
            end
          end
          lenblk_r <= (pos >= 6'd56);
          fin_r <= (pos < 6'd56);
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
          rnd_r <= '0;
          st_r <= S_RND;
        end
        S_RND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= t;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd79) st_r <= S_ADD;
        end
        S_ADD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
          rnd_r <= '0;
          if (pad_r) begin
            pad_r <= 1'b0;
            st_r <= S_PAD;
          end else if (lenblk_r) begin
            for (int i = 0; i < 16; i++) begin
              if (i == 14) w_r[i] <= len_r[63:32];
              else if (i == 15) w_r[i] <= len_r[31:0];
              else w_r[i] <= '0;
            end
            lenblk_r <= 1'b0;
            fin_r <= 1'b1;
            st_r <= S_LOAD;
          end else if (fin_r) begin
            oidx_r <= '0;
            st_r <= S_OUT;
          end else begin
            st_r <= S_IDLE;
          end
        end
        S_LOAD: begin
          // length-only block after a full padding block
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
          st_r <= S_RND;
        end
        S_OUT: if (!out_stall) begin
          if (oidx_r == 3'd4) begin
            oidx_r <= '0;
            h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
            len_r <= '0;
            fin_r <= 1'b0;
            st_r <= S_IDLE;
          end else begin
            oidx_r <= oidx_r + 3'd1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* tb/sha1_digest_checker.sv */
// Checker: watches both channels, computes SHA-1 digests and compares words.
`timescale 1ns / 1ps
module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          words_pending
);
  import sha1_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q[$];
  logic [31:0]  blk[16];
  logic [31:0]  hash[5];
  logic [63:0]  bit_len;

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic run_rounds();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash[0]; b = hash[1]; c = hash[2]; d = hash[3]; e = hash[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rotl(a, 5) + f + e + k + w[r];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    hash[0] += a; hash[1] += b; hash[2] += c; hash[3] += d; hash[4] += e;
  endtask

  task automatic place_byte(int pos, logic [7:0] v);
    logic [31:0] sh;
    sh = {v, 24'd0} >> (8 * (pos % 4));
    if (pos % 4 == 0) blk[pos/4] = sh;
    else blk[pos/4] |= sh;
  endtask

  task automatic absorb_item(logic [7:0] v, logic present, logic eom);
    int pos;
    digest_word_t dw;
    if (present) begin
      pos = int'(bit_len[8:3]);
      place_byte(pos, v);
      bit_len += 64'd8;
      if (pos == 63) run_rounds();
    end
    if (eom) begin
      pos = int'(bit_len[8:3]);
      place_byte(pos, PadByte);
      for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
      if (pos >= 56) begin
        run_rounds();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      blk[14] = bit_len[63:32];
      blk[15] = bit_len[31:0];
      run_rounds();
      for (int i = 0; i < 5; i++) begin
        dw.word = hash[i]; dw.index = 3'(i); dw.last = (i == 4);
        digest_q.push_back(dw);
      end
      hash = '{H0, H1, H2, H3, H4};
      bit_len = '0;
    end
  endtask

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      digest_q.delete();
      hash = '{H0, H1, H2, H3, H4};
      bit_len = '0;
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        absorb_item(in_data_byte, in_byte_present, in_end_of_message);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d", $time, out_digest_word,
                   out_word_index);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = digest_q.pop_front();
          if (exp_w.word !== out_digest_word || exp_w.index !== out_word_index ||
              exp_w.last !== out_last_word) begin
            $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                     exp_w.word, exp_w.index, exp_w.last,
                     out_digest_word, out_word_index, out_last_word);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    words_pending <= digest_q.size();
  end
endmodule

/* tb/tb_sha1_message_digest.sv */
// Testbench top: drives byte stream, stalls the digest side, reports verdict.
`timescale 1ns / 1ps
module tb_sha1_message_digest;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count;
  int          words_pending;
  bit          quiet_tail = 1'b0;   // no idling on either side near the end
  bit          long_hold = 1'b0;    // receiver holds off for a long stretch
  int          sent = 0;

  always #10 clk = ~clk;

  sha1_message_digest i_dut (.*);

  sha1_digest_checker i_checker (.*);

  // Receiver: random stall bursts, plus one long hold-off while input piles up.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // One transaction; valid stays high across back-to-back items.
  task automatic send_item(logic [7:0] b, logic present, logic eom);
    int n;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_byte_present <= present;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_message(int len, bit empty_close);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, (i == len - 1) && !empty_close);
    if (empty_close || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, extreme bytes, idle items, boundary lengths.
    send_message(0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);             // idle item, ignored
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);             // idle with nonzero byte
    send_item(8'h5A, 1'b1, 1'b1);
    send_message(3, 1'b1);
    drain_idle();                              // sender pauses until all digests arrive

    // Padding at the block boundary: 55, 56, 63, 64 bytes.
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    send_message(63, 1'b1);
    send_message(64, 1'b0);

    // Backpressure: receiver holds while short messages keep coming.
    long_hold = 1'b1;
    for (int m = 0; m < 6; m++) send_message($urandom_range(1, 4), $urandom_range(0, 1));

    // Random part: mostly short messages, some idle items, occasional longer ones.
    while (sent < 450) begin
      if (sent > 380) quiet_tail = 1'b1;
      if ($urandom_range(0, 7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      else begin
        len = (sent < 380 && $urandom_range(0, 9) == 0) ? $urandom_range(50, 130)
                                                         : $urandom_range(0, 8);
        send_message(len, $urandom_range(0, 3) == 0);
      end
    end
    drain_idle();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
